@@ src/rmsmm_pkg.sv @@
// Package for the running mean, deviation, min and max unit.
// Holds the shared constants, register map, queue status type and back-end states.
// No dependencies.
package rmsmm_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int FIELD_BITS      = 24;

    localparam int CFG_DATA_BITS   = 32;
    localparam int CFG_ADDR_BITS   = 3;
    localparam int RUN_LENGTH_BITS = 16;
    localparam logic [RUN_LENGTH_BITS-1:0] RUN_LENGTH_RESET = 16'd1;
    localparam logic REG_RUN_LENGTH = 1'b0;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                 empty;
        logic                 full;
        logic [QCNT_BITS-1:0] count;
    } queue_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV_SUM,
        BK_DIV_SQ,
        BK_SQUARE,
        BK_VAR,
        BK_SQRT,
        BK_DONE
    } back_state_t;

endpackage

@@ src/rmsmm_queue.sv @@
// Short queue of finished run totals between the accumulator front and the math back end.
// Depends on rmsmm_pkg for its depth and status type.
module rmsmm_queue
    import rmsmm_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output queue_status_t    status
);

    logic [WIDTH-1:0]     mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign do_push = push && (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign status.count = count_reg;

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("queue pushed while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ src/rmsmm_front.sv @@
// Front end: takes samples, squares them, keeps sum, sum of squares, min and max per run.
// Depends on rmsmm_pkg; pushes finished run totals into rmsmm_queue.
module rmsmm_front
    import rmsmm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int SUM_BITS    = SAMPLE_BITS + COUNT_BITS,
    parameter int SQ_BITS     = 2 * SAMPLE_BITS + COUNT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [COUNT_BITS-1:0]  run_length,
    input  logic                   push,
    output logic                   full,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  queue_status_t          q_status,
    output logic                   q_push,
    output logic [SUM_BITS-1:0]    q_sum,
    output logic [SQ_BITS-1:0]     q_square_sum,
    output logic [SAMPLE_BITS-1:0] q_min,
    output logic [SAMPLE_BITS-1:0] q_max,
    output logic [COUNT_BITS-1:0]  q_count
);

    logic [COUNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                     stg_vld_reg, stg_vld_next;
    logic                     stg_last_reg, stg_last_next;
    logic [SAMPLE_BITS-1:0]   stg_s_reg, stg_s_next;
    logic [2*SAMPLE_BITS-1:0] stg_sq_reg, stg_sq_next;
    logic [COUNT_BITS-1:0]    stg_n_reg, stg_n_next;
    logic [SUM_BITS-1:0]      sum_reg, sum_next;
    logic [SQ_BITS-1:0]       sqs_reg, sqs_next;
    logic [SAMPLE_BITS-1:0]   min_reg, min_next;
    logic [SAMPLE_BITS-1:0]   max_reg, max_next;

    logic [COUNT_BITS-1:0]    target;
    logic [COUNT_BITS:0]      cnt_inc;
    logic                     is_last;
    logic                     accept;
    logic [QCNT_BITS:0]       reserved;
    logic [SUM_BITS-1:0]      sum_add;
    logic [SQ_BITS-1:0]       sqs_add;
    logic [SAMPLE_BITS-1:0]   min_upd;
    logic [SAMPLE_BITS-1:0]   max_upd;

    assign target   = (run_length == '0) ? COUNT_BITS'(1) : run_length;
    assign cnt_inc  = {1'b0, cnt_reg} + 1'b1;
    assign is_last  = cnt_inc >= {1'b0, target};
    assign reserved = {1'b0, q_status.count} + (QCNT_BITS + 1)'(stg_vld_reg && stg_last_reg);
    assign full     = reserved >= (QCNT_BITS + 1)'(QUEUE_DEPTH);
    assign accept   = push && !full;

    assign sum_add = sum_reg + SUM_BITS'(stg_s_reg);
    assign sqs_add = sqs_reg + SQ_BITS'(stg_sq_reg);
    assign min_upd = (stg_s_reg < min_reg) ? stg_s_reg : min_reg;
    assign max_upd = (stg_s_reg > max_reg) ? stg_s_reg : max_reg;

    assign q_push       = stg_vld_reg && stg_last_reg;
    assign q_sum        = sum_add;
    assign q_square_sum = sqs_add;
    assign q_min        = min_upd;
    assign q_max        = max_upd;
    assign q_count      = stg_n_reg;

    always_comb
    begin
        cnt_next      = cnt_reg;
        stg_vld_next  = accept;
        stg_last_next = stg_last_reg;
        stg_s_next    = stg_s_reg;
        stg_sq_next   = stg_sq_reg;
        stg_n_next    = stg_n_reg;
        sum_next      = sum_reg;
        sqs_next      = sqs_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        if (accept)
        begin
            cnt_next      = is_last ? '0 : cnt_inc[COUNT_BITS-1:0];
            stg_last_next = is_last;
            stg_s_next    = sample;
            stg_sq_next   = (2 * SAMPLE_BITS)'(sample) * (2 * SAMPLE_BITS)'(sample);
            stg_n_next    = cnt_inc[COUNT_BITS-1:0];
        end
        if (stg_vld_reg)
        begin
            if (stg_last_reg)
            begin
                sum_next = '0;
                sqs_next = '0;
                min_next = '1;
                max_next = '0;
            end
            else
            begin
                sum_next = sum_add;
                sqs_next = sqs_add;
                min_next = min_upd;
                max_next = max_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            stg_vld_reg  <= 1'b0;
            stg_last_reg <= 1'b0;
            sum_reg      <= '0;
            sqs_reg      <= '0;
            min_reg      <= '1;
            max_reg      <= '0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            stg_vld_reg  <= stg_vld_next;
            stg_last_reg <= stg_last_next;
            sum_reg      <= sum_next;
            sqs_reg      <= sqs_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_s_reg  <= stg_s_next;
        stg_sq_reg <= stg_sq_next;
        stg_n_reg  <= stg_n_next;
    end

    a_clear_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_vld_reg && stg_last_reg) |=> (sum_reg == '0 && sqs_reg == '0 && max_reg == '0))
        else $error("accumulators not cleared after run end");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("run end with no queue room");

    a_count_below_target: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (cnt_reg < target || cnt_reg == '0))
        else $error("sample count ran past run length");

endmodule

@@ src/rmsmm_back.sv @@
// Back end: divides run totals by the count, forms the variance, takes its square root.
// Depends on rmsmm_pkg; pops run totals from rmsmm_queue and holds one result register.
module rmsmm_back
    import rmsmm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int SUM_BITS    = SAMPLE_BITS + COUNT_BITS,
    parameter int SQ_BITS     = 2 * SAMPLE_BITS + COUNT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  queue_status_t          q_status,
    output logic                   q_pop,
    input  logic [SUM_BITS-1:0]    q_sum,
    input  logic [SQ_BITS-1:0]     q_square_sum,
    input  logic [SAMPLE_BITS-1:0] q_min,
    input  logic [SAMPLE_BITS-1:0] q_max,
    input  logic [COUNT_BITS-1:0]  q_count,
    output logic                   empty,
    input  logic                   pop,
    output logic [SAMPLE_BITS-1:0] mean_value,
    output logic [SAMPLE_BITS-1:0] std_deviation,
    output logic [SAMPLE_BITS-1:0] min_value,
    output logic [SAMPLE_BITS-1:0] max_value
);

    localparam int VW = 2 * SAMPLE_BITS;
    localparam int IW = $clog2(SQ_BITS + 1);

    back_state_t            state_reg, state_next;
    logic [IW-1:0]          iter_reg, iter_next;
    logic [COUNT_BITS-1:0]  n_reg, n_next;
    logic [COUNT_BITS-1:0]  rem_reg, rem_next;
    logic [SQ_BITS-1:0]     quo_reg, quo_next;
    logic [SQ_BITS-1:0]     sqs_reg, sqs_next;
    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [SAMPLE_BITS-1:0] mean_reg, mean_next;
    logic [VW-1:0]          msq_reg, msq_next;
    logic [VW-1:0]          v_reg, v_next;
    logic [VW-1:0]          root_reg, root_next;
    logic [VW-1:0]          bit_reg, bit_next;
    logic                   out_vld_reg, out_vld_next;
    logic [SAMPLE_BITS-1:0] o_mean_reg, o_mean_next;
    logic [SAMPLE_BITS-1:0] o_std_reg, o_std_next;
    logic [SAMPLE_BITS-1:0] o_min_reg, o_min_next;
    logic [SAMPLE_BITS-1:0] o_max_reg, o_max_next;

    logic [COUNT_BITS:0]    div_shift;
    logic                   div_ge;
    logic [COUNT_BITS:0]    div_diff;
    logic [COUNT_BITS-1:0]  div_rem;
    logic [SQ_BITS-1:0]     div_quo;
    logic [VW-1:0]          sq_trial;
    logic                   sq_ge;
    logic [VW-1:0]          q_low;
    logic                   last_iter;

    assign div_shift = {rem_reg, quo_reg[SQ_BITS-1]};
    assign div_ge    = div_shift >= {1'b0, n_reg};
    assign div_diff  = div_shift - {1'b0, n_reg};
    assign div_rem   = div_ge ? div_diff[COUNT_BITS-1:0] : div_shift[COUNT_BITS-1:0];
    assign div_quo   = {quo_reg[SQ_BITS-2:0], div_ge};
    assign sq_trial  = root_reg + bit_reg;
    assign sq_ge     = v_reg >= sq_trial;
    assign q_low     = quo_reg[VW-1:0];
    assign last_iter = (iter_reg == IW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iter_reg   <= iter_next;
        n_reg      <= n_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        sqs_reg    <= sqs_next;
        min_reg    <= min_next;
        max_reg    <= max_next;
        mean_reg   <= mean_next;
        msq_reg    <= msq_next;
        v_reg      <= v_next;
        root_reg   <= root_next;
        bit_reg    <= bit_next;
        o_mean_reg <= o_mean_next;
        o_std_reg  <= o_std_next;
        o_min_reg  <= o_min_next;
        o_max_reg  <= o_max_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        iter_next    = iter_reg;
        n_next       = n_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        sqs_next     = sqs_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        mean_next    = mean_reg;
        msq_next     = msq_reg;
        v_next       = v_reg;
        root_next    = root_reg;
        bit_next     = bit_reg;
        o_mean_next  = o_mean_reg;
        o_std_next   = o_std_reg;
        o_min_next   = o_min_reg;
        o_max_next   = o_max_reg;
        out_vld_next = out_vld_reg && !pop;
        q_pop        = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop      = 1'b1;
                    n_next     = q_count;
                    sqs_next   = q_square_sum;
                    min_next   = q_min;
                    max_next   = q_max;
                    rem_next   = '0;
                    quo_next   = {q_sum, {(SQ_BITS - SUM_BITS){1'b0}}};
                    iter_next  = IW'(SUM_BITS);
                    state_next = BK_DIV_SUM;
                end
            end
            BK_DIV_SUM:
            begin
                rem_next  = div_rem;
                quo_next  = div_quo;
                iter_next = iter_reg - 1'b1;
                if (last_iter)
                begin
                    mean_next  = div_quo[SAMPLE_BITS-1:0];
                    rem_next   = '0;
                    quo_next   = sqs_reg;
                    iter_next  = IW'(SQ_BITS);
                    state_next = BK_DIV_SQ;
                end
            end
            BK_DIV_SQ:
            begin
                rem_next  = div_rem;
                quo_next  = div_quo;
                iter_next = iter_reg - 1'b1;
                if (last_iter)
                begin
                    state_next = BK_SQUARE;
                end
            end
            BK_SQUARE:
            begin
                msq_next   = VW'(mean_reg) * VW'(mean_reg);
                state_next = BK_VAR;
            end
            BK_VAR:
            begin
                v_next     = (q_low > msq_reg) ? (q_low - msq_reg) : '0;
                root_next  = '0;
                bit_next   = VW'(1) << (VW - 2);
                iter_next  = IW'(SAMPLE_BITS);
                state_next = BK_SQRT;
            end
            BK_SQRT:
            begin
                if (sq_ge)
                begin
                    v_next    = v_reg - sq_trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                iter_next = iter_reg - 1'b1;
                if (last_iter)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!out_vld_reg || pop)
                begin
                    o_mean_next  = mean_reg;
                    o_std_next   = root_reg[SAMPLE_BITS-1:0];
                    o_min_next   = min_reg;
                    o_max_next   = max_reg;
                    out_vld_next = 1'b1;
                    state_next   = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign empty         = !out_vld_reg;
    assign mean_value    = o_mean_reg;
    assign std_deviation = o_std_reg;
    assign min_value     = o_min_reg;
    assign max_value     = o_max_reg;

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (o_min_reg <= o_max_reg))
        else $error("result min above max");

    a_mean_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (o_mean_reg >= o_min_reg && o_mean_reg <= o_max_reg))
        else $error("result mean outside min and max");

    a_std_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (o_std_reg <= o_max_reg))
        else $error("result deviation above max");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !pop) |=> (out_vld_reg && $stable(o_mean_reg) && $stable(o_std_reg)))
        else $error("waiting result changed");

endmodule

@@ src/running_mean_stddev_min_max_unit.sv @@
// Running mean, standard deviation, minimum and maximum over runs of samples.
// Top level: APB run length register, front accumulator, run queue, back math unit.
// Depends on rmsmm_pkg, rmsmm_front, rmsmm_queue and rmsmm_back.
//
// Samples enter through push/full, one per cycle while full is low. Each run of
// run_length samples (zero acts as one) yields one request on the result side:
// mean, standard deviation, minimum and maximum, held while empty is low and
// taken with pop. run_length sits at byte address 0 of the APB port and may be
// written only while no run is in progress.
// The front squares and accumulates every sample at one per cycle while full is
// low. A finished run moves through a two-entry queue to the back end, which pops
// it in BK_IDLE, then runs a one-bit-per-cycle restoring divider (mean and mean
// of squares) in BK_DIV_SUM and BK_DIV_SQ, forms the square and difference in
// BK_SQUARE and BK_VAR, runs a one-bit-per-cycle square root in BK_SQRT and
// loads the result register in BK_DONE. The back end takes the next run from the
// queue only once the result of the last one is loaded.
// A stalled result holds the back end; the queue then fills and full rises at
// the run end that fills it. Reset clears the front sums, sets the running min to
// all ones and max to zero, empties the queue, drops any waiting result and sets
// run_length to one.
module running_mean_stddev_min_max_unit
    import rmsmm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     push,
    output logic                     full,
    input  logic [FIELD_BITS-1:0]    sample,
    output logic                     empty,
    input  logic                     pop,
    output logic [FIELD_BITS-1:0]    mean_value,
    output logic [FIELD_BITS-1:0]    std_deviation,
    output logic [FIELD_BITS-1:0]    min_value,
    output logic [FIELD_BITS-1:0]    max_value
);

    localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_BITS  = 2 * SAMPLE_BITS + COUNT_BITS;
    localparam int QW       = SUM_BITS + SQ_BITS + 2 * SAMPLE_BITS + COUNT_BITS;

    logic [RUN_LENGTH_BITS-1:0] run_length_reg, run_length_next;
    logic                       cfg_write;
    logic                       sel_run_length;

    queue_status_t              q_status;
    logic                       q_push;
    logic                       q_pop;
    logic [QW-1:0]              q_wdata;
    logic [QW-1:0]              q_rdata;
    logic [SUM_BITS-1:0]        f_sum;
    logic [SQ_BITS-1:0]         f_sqs;
    logic [SAMPLE_BITS-1:0]     f_min;
    logic [SAMPLE_BITS-1:0]     f_max;
    logic [COUNT_BITS-1:0]      f_n;
    logic [SUM_BITS-1:0]        b_sum;
    logic [SQ_BITS-1:0]         b_sqs;
    logic [SAMPLE_BITS-1:0]     b_min;
    logic [SAMPLE_BITS-1:0]     b_max;
    logic [COUNT_BITS-1:0]      b_n;
    logic [SAMPLE_BITS-1:0]     r_mean;
    logic [SAMPLE_BITS-1:0]     r_std;
    logic [SAMPLE_BITS-1:0]     r_min;
    logic [SAMPLE_BITS-1:0]     r_max;

    assign pready         = 1'b1;
    assign sel_run_length = (paddr[CFG_ADDR_BITS-1] == REG_RUN_LENGTH);
    assign cfg_write      = psel && penable && pwrite && pready;

    always_comb
    begin
        run_length_next = run_length_reg;
        if (cfg_write && sel_run_length)
        begin
            run_length_next = pwdata[RUN_LENGTH_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_length_reg <= RUN_LENGTH_RESET;
        end
        else
        begin
            run_length_reg <= run_length_next;
        end
    end

    assign prdata = sel_run_length ? CFG_DATA_BITS'(run_length_reg) : '0;

    rmsmm_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .SUM_BITS    (SUM_BITS),
        .SQ_BITS     (SQ_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .run_length   (run_length_reg[COUNT_BITS-1:0]),
        .push         (push),
        .full         (full),
        .sample       (sample[SAMPLE_BITS-1:0]),
        .q_status     (q_status),
        .q_push       (q_push),
        .q_sum        (f_sum),
        .q_square_sum (f_sqs),
        .q_min        (f_min),
        .q_max        (f_max),
        .q_count      (f_n)
    );

    assign q_wdata = {f_sum, f_sqs, f_min, f_max, f_n};

    rmsmm_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .status    (q_status)
    );

    assign {b_sum, b_sqs, b_min, b_max, b_n} = q_rdata;

    rmsmm_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .SUM_BITS    (SUM_BITS),
        .SQ_BITS     (SQ_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .q_pop         (q_pop),
        .q_sum         (b_sum),
        .q_square_sum  (b_sqs),
        .q_min         (b_min),
        .q_max         (b_max),
        .q_count       (b_n),
        .empty         (empty),
        .pop           (pop),
        .mean_value    (r_mean),
        .std_deviation (r_std),
        .min_value     (r_min),
        .max_value     (r_max)
    );

    assign mean_value    = FIELD_BITS'(r_mean);
    assign std_deviation = FIELD_BITS'(r_std);
    assign min_value     = FIELD_BITS'(r_min);
    assign max_value     = FIELD_BITS'(r_max);

endmodule
